// ===== src/wdt_pkg.sv =====
package wdt_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int CTL_WIDTH   = 3;

    localparam logic [DATA_WIDTH-1:0] RESTART_KEY = 32'h0000_5ab9;

    localparam int CTL_ENABLE_BIT = 0;
    localparam int CTL_RESET_BIT  = 1;
    localparam int CTL_INTR_BIT   = 2;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [2:0] REG_COUNTER = 3'd0;
    localparam logic [2:0] REG_LOAD    = 3'd1;
    localparam logic [2:0] REG_RESTART = 3'd2;
    localparam logic [2:0] REG_CONTROL = 3'd3;
    localparam logic [2:0] REG_STATUS  = 3'd4;
    localparam logic [2:0] REG_CLEAR   = 3'd5;
    localparam logic [2:0] REG_INTR    = 3'd6;

    typedef struct packed {
        logic [1:0]            action;
        logic [2:0]            reg_index;
        logic [DATA_WIDTH-1:0] write_data;
    } cmd_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  interrupt_out;
        logic                  reset_out;
        logic                  expired;
    } rsp_t;

endpackage

// ===== src/wdt_cmd_if.sv =====
interface wdt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  reg_index;
    logic [31:0] write_data;

    modport source (output valid, output action, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input action, input reg_index, input write_data,
                  output ready);
endinterface

// ===== src/wdt_rsp_if.sv =====
interface wdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        interrupt_out;
    logic        reset_out;
    logic        expired;

    modport source (output valid, output read_data, output interrupt_out,
                    output reset_out, output expired, input ready);
    modport sink (input valid, input read_data, input interrupt_out,
                  input reset_out, input expired, output ready);
endinterface

// ===== src/wdt_core.sv =====
module wdt_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  wdt_pkg::cmd_t  cmd,
    output wdt_pkg::rsp_t  rsp
);

    logic [wdt_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic [wdt_pkg::COUNT_WIDTH-1:0] load_reg, load_next;
    logic [wdt_pkg::CTL_WIDTH-1:0]   ctl_reg, ctl_next;
    logic                            expired_reg, expired_next;
    logic [wdt_pkg::DATA_WIDTH-1:0]  plen_reg, plen_next;
    logic [wdt_pkg::DATA_WIDTH-1:0]  prem_reg, prem_next;
    logic                            rstreq_reg, rstreq_next;

    logic [wdt_pkg::COUNT_WIDTH-1:0] count_dec;
    logic [wdt_pkg::DATA_WIDTH-1:0]  prem_dec;
    logic [wdt_pkg::DATA_WIDTH-1:0]  rd_data;
    logic                            enabled;
    logic                            expire;

    assign enabled   = ctl_reg[wdt_pkg::CTL_ENABLE_BIT];
    assign count_dec = (enabled && (count_reg != '0)) ? count_reg - 1'b1 : count_reg;
    assign expire    = enabled && (count_dec == '0) && !expired_reg;
    assign prem_dec  = (prem_reg != '0) ? prem_reg - 1'b1 : prem_reg;

    always_comb
    begin
        count_next   = count_reg;
        load_next    = load_reg;
        ctl_next     = ctl_reg;
        expired_next = expired_reg;
        plen_next    = plen_reg;
        prem_next    = prem_reg;
        rstreq_next  = rstreq_reg;
        rd_data      = '0;
        case (cmd.action)
            wdt_pkg::ACT_TICK:
            begin
                count_next = count_dec;
                if (expire)
                begin
                    expired_next = 1'b1;
                    if (ctl_reg[wdt_pkg::CTL_RESET_BIT])
                        rstreq_next = 1'b1;
                    if (ctl_reg[wdt_pkg::CTL_INTR_BIT])
                        prem_next = plen_reg;
                    else
                        prem_next = prem_dec;
                end
                else
                    prem_next = prem_dec;
            end
            wdt_pkg::ACT_WRITE:
            begin
                case (cmd.reg_index)
                    wdt_pkg::REG_LOAD:
                        load_next = cmd.write_data[wdt_pkg::COUNT_WIDTH-1:0];
                    wdt_pkg::REG_RESTART:
                        if (cmd.write_data == wdt_pkg::RESTART_KEY)
                            count_next = load_reg;
                    wdt_pkg::REG_CONTROL:
                        ctl_next = cmd.write_data[wdt_pkg::CTL_WIDTH-1:0];
                    wdt_pkg::REG_CLEAR:
                        expired_next = 1'b0;
                    wdt_pkg::REG_INTR:
                        plen_next = cmd.write_data;
                    default: ;
                endcase
            end
            wdt_pkg::ACT_READ:
            begin
                case (cmd.reg_index)
                    wdt_pkg::REG_COUNTER:
                        rd_data = wdt_pkg::DATA_WIDTH'(count_reg);
                    wdt_pkg::REG_LOAD:
                        rd_data = wdt_pkg::DATA_WIDTH'(load_reg);
                    wdt_pkg::REG_CONTROL:
                        rd_data = wdt_pkg::DATA_WIDTH'(ctl_reg);
                    wdt_pkg::REG_STATUS:
                        rd_data = wdt_pkg::DATA_WIDTH'(expired_reg);
                    wdt_pkg::REG_INTR:
                        rd_data = plen_reg;
                    default:
                        rd_data = '0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            load_reg    <= '0;
            ctl_reg     <= '0;
            expired_reg <= 1'b0;
            plen_reg    <= '0;
            prem_reg    <= '0;
            rstreq_reg  <= 1'b0;
        end
        else if (fire)
        begin
            count_reg   <= count_next;
            load_reg    <= load_next;
            ctl_reg     <= ctl_next;
            expired_reg <= expired_next;
            plen_reg    <= plen_next;
            prem_reg    <= prem_next;
            rstreq_reg  <= rstreq_next;
        end
    end

    assign rsp.read_data     = rd_data;
    assign rsp.interrupt_out = (prem_next != '0);
    assign rsp.reset_out     = rstreq_next;
    assign rsp.expired       = expired_next;

    a_rstreq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rstreq_reg |=> rstreq_reg)
        else $error("reset request dropped");

    a_status_rise_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(expired_reg) |-> $past(fire && (cmd.action == wdt_pkg::ACT_TICK)))
        else $error("status set outside a tick");

    a_count_change_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(fire && ((cmd.action == wdt_pkg::ACT_TICK)
            || ((cmd.action == wdt_pkg::ACT_WRITE)
                && (cmd.reg_index == wdt_pkg::REG_RESTART)))))
        else $error("counter changed without tick or restart");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cmd.action == wdt_pkg::ACT_TICK) && !enabled) |=> $stable(count_reg))
        else $error("disabled counter moved");

endmodule

// ===== src/watchdog_timer_registers.sv =====
// Channel | Dir | Beat contents
// cmd     | in  | action, reg_index, write_data
// rsp     | out | read_data, interrupt_out, reset_out, expired
//
// One beat per cycle sustained while rsp is ready; each command beat goes
// through the command register, then the output register, to reach rsp.
// The command register feeds the register file and its update logic.
// rst_n clears valid flags, counter, load, control, status, pulse, reset request.
// A stalled rsp holds its beat; cmd keeps taking one more beat into its register,
// then drops ready until rsp drains.
module watchdog_timer_registers (
    input  logic      clk,
    input  logic      rst_n,
    wdt_cmd_if.sink   cmd,
    wdt_rsp_if.source rsp
);

    logic           s1_valid_reg, s1_valid_next;
    wdt_pkg::cmd_t  s1_cmd_reg;
    logic           out_valid_reg, out_valid_next;
    wdt_pkg::rsp_t  out_rsp_reg;
    wdt_pkg::rsp_t  core_rsp;
    logic           advance;
    logic           cmd_fire;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_cmd_reg.action     <= cmd.action;
            s1_cmd_reg.reg_index  <= cmd.reg_index;
            s1_cmd_reg.write_data <= cmd.write_data;
        end
        if (advance)
            out_rsp_reg <= core_rsp;
    end

    wdt_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cmd   (s1_cmd_reg),
        .rsp   (core_rsp)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_rsp_reg.read_data;
    assign rsp.interrupt_out = out_rsp_reg.interrupt_out;
    assign rsp.reset_out     = out_rsp_reg.reset_out;
    assign rsp.expired       = out_rsp_reg.expired;

endmodule

// ===== dv/wdt_tb_pkg.sv =====
`timescale 1ns / 1ps

package wdt_tb_pkg;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [2:0] REG_SPARE = 3'd7;

    class wdt_response_board;

        logic [wdt_pkg::COUNT_WIDTH-1:0] counter;
        logic [wdt_pkg::COUNT_WIDTH-1:0] reload;
        logic [wdt_pkg::CTL_WIDTH-1:0]   control;
        logic                            expired_flag;
        logic [wdt_pkg::DATA_WIDTH-1:0]  pulse_len;
        logic [wdt_pkg::DATA_WIDTH-1:0]  pulse_left;
        logic                            reset_req;
        wdt_pkg::rsp_t                   pending_rsp[$];
        int                              errors;

        function new();
            counter      = '0;
            reload       = '0;
            control      = '0;
            expired_flag = 1'b0;
            pulse_len    = '0;
            pulse_left   = '0;
            reset_req    = 1'b0;
            errors       = 0;
        endfunction

        function wdt_pkg::rsp_t apply_command(wdt_pkg::cmd_t c);
            wdt_pkg::rsp_t r;
            logic enabled;
            r = '0;
            enabled = control[wdt_pkg::CTL_ENABLE_BIT];
            case (c.action)
                wdt_pkg::ACT_TICK:
                begin
                    if (enabled && counter != '0)
                        counter = counter - 1'b1;
                    if (enabled && counter == '0 && !expired_flag)
                    begin
                        expired_flag = 1'b1;
                        if (control[wdt_pkg::CTL_RESET_BIT])
                            reset_req = 1'b1;
                        if (control[wdt_pkg::CTL_INTR_BIT])
                            pulse_left = pulse_len;
                        else if (pulse_left != '0)
                            pulse_left = pulse_left - 1'b1;
                    end
                    else if (pulse_left != '0)
                    begin
                        pulse_left = pulse_left - 1'b1;
                    end
                end
                wdt_pkg::ACT_WRITE:
                begin
                    case (c.reg_index)
                        wdt_pkg::REG_LOAD:
                            reload = c.write_data[wdt_pkg::COUNT_WIDTH-1:0];
                        wdt_pkg::REG_RESTART:
                            if (c.write_data == wdt_pkg::RESTART_KEY)
                                counter = reload;
                        wdt_pkg::REG_CONTROL:
                            control = c.write_data[wdt_pkg::CTL_WIDTH-1:0];
                        wdt_pkg::REG_CLEAR:
                            expired_flag = 1'b0;
                        wdt_pkg::REG_INTR:
                            pulse_len = c.write_data;
                        default: ;
                    endcase
                end
                wdt_pkg::ACT_READ:
                begin
                    case (c.reg_index)
                        wdt_pkg::REG_COUNTER:
                            r.read_data = wdt_pkg::DATA_WIDTH'(counter);
                        wdt_pkg::REG_LOAD:
                            r.read_data = wdt_pkg::DATA_WIDTH'(reload);
                        wdt_pkg::REG_CONTROL:
                            r.read_data = wdt_pkg::DATA_WIDTH'(control);
                        wdt_pkg::REG_STATUS:
                            r.read_data = wdt_pkg::DATA_WIDTH'(expired_flag);
                        wdt_pkg::REG_INTR:
                            r.read_data = pulse_len;
                        default:
                            r.read_data = '0;
                    endcase
                end
                default: ;
            endcase
            r.interrupt_out = (pulse_left != '0);
            r.reset_out     = reset_req;
            r.expired       = expired_flag;
            return r;
        endfunction

        function void note_command(wdt_pkg::cmd_t c);
            pending_rsp.push_back(apply_command(c));
        endfunction

        function void check_response(wdt_pkg::rsp_t got);
            wdt_pkg::rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with nothing pending: read_data %h", got.read_data);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                errors++;
            end
            if (got.interrupt_out !== want.interrupt_out)
            begin
                $error("interrupt_out: expected %b, got %b", want.interrupt_out,
                       got.interrupt_out);
                errors++;
            end
            if (got.reset_out !== want.reset_out)
            begin
                $error("reset_out: expected %b, got %b", want.reset_out, got.reset_out);
                errors++;
            end
            if (got.expired !== want.expired)
            begin
                $error("expired: expected %b, got %b", want.expired, got.expired);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== dv/watchdog_timer_registers_test.sv =====
`timescale 1ns / 1ps

module watchdog_timer_registers_test;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_BEATS = 410;

    logic clk = 1'b0;
    logic rst_n;

    wdt_cmd_if cmd ();
    wdt_rsp_if rsp ();

    watchdog_timer_registers u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    wdt_tb_pkg::wdt_response_board board;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int beats_sent;
    int quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        rsp.ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (!rst_n)
            begin
                rsp.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cmd.valid && cmd.ready)
                board.note_command(wdt_pkg::cmd_t'{action: cmd.action,
                                                   reg_index: cmd.reg_index,
                                                   write_data: cmd.write_data});
            if (rsp.valid && rsp.ready)
                board.check_response(wdt_pkg::rsp_t'{read_data: rsp.read_data,
                                                     interrupt_out: rsp.interrupt_out,
                                                     reset_out: rsp.reset_out,
                                                     expired: rsp.expired});
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog_timer_registers_test failed");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [1:0] act, input logic [2:0] idx,
                            input logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.action     <= act;
        cmd.reg_index  <= idx;
        cmd.write_data <= data;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (act != wdt_tb_pkg::ACT_SPARE)
            beats_sent++;
    endtask

    task automatic drain_responses();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int          target;
        int          n_ticks;
        logic [31:0] ctl_word;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            if ($urandom_range(99) < 75)
            begin
                push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_LOAD,
                         ($urandom_range(9) == 0) ? $urandom : $urandom_range(12));
                if ($urandom_range(1) == 1)
                    push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_INTR,
                             ($urandom_range(19) == 0) ? $urandom : $urandom_range(6));
                push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_RESTART,
                         ($urandom_range(9) == 0) ? $urandom : wdt_pkg::RESTART_KEY);
                ctl_word = $urandom;
                if ($urandom_range(3) != 0)
                    ctl_word[wdt_pkg::CTL_ENABLE_BIT] = 1'b1;
                push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CONTROL, ctl_word);
                n_ticks = $urandom_range(20);
                repeat (n_ticks)
                begin
                    if ($urandom_range(4) == 0)
                        push_cmd(wdt_pkg::ACT_READ, 3'($urandom_range(7)), $urandom);
                    push_cmd(wdt_pkg::ACT_TICK, 3'($urandom_range(7)), $urandom);
                end
                push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_STATUS, $urandom);
                if ($urandom_range(1) == 1)
                    push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CLEAR, $urandom);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_cmd(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom);
            end
        end
    endtask

    initial
    begin
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        beats_sent     = 0;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.action     = wdt_pkg::ACT_TICK;
        cmd.reg_index  = wdt_pkg::REG_COUNTER;
        cmd.write_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_COUNTER, 32'hffff_ffff);
        push_cmd(wdt_pkg::ACT_READ, wdt_tb_pkg::REG_SPARE, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_tb_pkg::REG_SPARE, 32'hffff_ffff);
        push_cmd(wdt_tb_pkg::ACT_SPARE, wdt_pkg::REG_LOAD, 32'hffff_ffff);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_LOAD, 32'hffff_ffff);
        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_LOAD, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_LOAD, 32'd3);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY ^ 32'h1);
        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_COUNTER, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_RESTART, wdt_pkg::RESTART_KEY);
        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_COUNTER, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_INTR, 32'd2);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CONTROL, 32'hffff_fffd);
        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_CONTROL, '0);
        repeat (5)
            push_cmd(wdt_pkg::ACT_TICK, wdt_tb_pkg::REG_SPARE, 32'hffff_ffff);
        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_STATUS, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CLEAR, '0);
        push_cmd(wdt_pkg::ACT_TICK, wdt_pkg::REG_COUNTER, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CONTROL, 32'd3);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CLEAR, 32'hffff_ffff);
        push_cmd(wdt_pkg::ACT_TICK, wdt_pkg::REG_COUNTER, '0);
        push_cmd(wdt_pkg::ACT_WRITE, wdt_pkg::REG_CONTROL, '0);
        push_cmd(wdt_pkg::ACT_READ, wdt_pkg::REG_INTR, '0);
        drain_responses();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (phase == 0)
            begin
                run_random(PHASE_BEATS / 2);
                hold_requests++;
                run_random(PHASE_BEATS / 2);
            end
            else
            begin
                run_random(PHASE_BEATS);
            end
            drain_responses();
        end

        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending_rsp.size() == 0)
            $display("watchdog_timer_registers_test passed");
        else
            $display("watchdog_timer_registers_test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/wdt_pkg.sv
src/wdt_cmd_if.sv
src/wdt_rsp_if.sv
src/wdt_core.sv
src/watchdog_timer_registers.sv
dv/wdt_tb_pkg.sv
dv/watchdog_timer_registers_test.sv
